FILE: rtl/packet_sync_fec_receiver_core_defines.svh
// Assertion macros of the packet receiver checker.
`ifndef PACKET_SYNC_FEC_RECEIVER_CORE_DEFINES_SVH
`define PACKET_SYNC_FEC_RECEIVER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PSFR_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("packet receiver check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PSFR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("packet receiver check failed");

`endif

FILE: rtl/psfr_pkg.sv
// Shared constants, types and helper functions of the packet receiver.
package psfr_pkg;

   localparam int FEC_BYTES_DEFAULT = 7;

   localparam int WINDOW_W    = 40;
   localparam int THRESH_W    = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int DIGIT_W     = 8;
   localparam int DIGITS      = WINDOW_W / DIGIT_W;

   localparam logic [WINDOW_W-1:0] SYNC_PATTERN_RESET   = 40'h07092a446f;
   localparam logic [THRESH_W-1:0] SYNC_THRESHOLD_RESET = 6'd32;
   localparam logic [THRESH_W-1:0] WINDOW_BITS          = 6'd40;
   localparam logic [3:0]          BITS_PER_BYTE        = 4'd8;
   localparam logic [7:0]          FEC_FIX_MASK         = 8'hA6;
   localparam logic [2:0]          FEC_VOTE_MIN         = 3'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_PATTERN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_THRESHOLD = 2'd1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BIT   = 6'b000010,
      ST_COUNT = 6'b000100,
      ST_DEINT = 6'b001000,
      ST_FEC   = 6'b010000,
      ST_PUSH  = 6'b100000
   } state_type;

   function automatic logic [3:0] popcount8(input logic [DIGIT_W-1:0] value);
      logic [3:0] sum;
      sum = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         sum = sum + {3'b000, value[i]};
      end
      return sum;
   endfunction

endpackage

FILE: rtl/psfr_if.sv
// Channel interfaces of the packet receiver: input bytes, results and register writes.
interface psfr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface psfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic [7:0]  argument;
   logic [15:0] unit_ident;
   logic [15:0] crc_field;

   modport source (output valid, output opcode, output argument, output unit_ident,
                   output crc_field, input ready);
   modport sink (input valid, input opcode, input argument, input unit_ident,
                 input crc_field, output ready);
endinterface

interface psfr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [psfr_pkg::CSR_INDEX_W-1:0]   index;
   logic [psfr_pkg::WINDOW_W-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/packet_sync_fec_receiver_core.sv
// Sync-word framed packet receiver with deinterleaving and syndrome error correction.
//
// The req channel carries one received byte per transfer, taken most significant
// bit first; a transfer with kind set clears the receiver. Each data byte is
// worked one bit per cycle. While hunting with a full window, every bit also
// takes a correlation pass, one byte of the window per cycle, and req_ready
// returns only when the whole byte is done. When the last packet bit arrives,
// a deinterleave pass over all packet bits and a correction pass over the data
// bits run bit serially, then the ST_PUSH state moves the result into the rsp
// output register. The rest of that byte is dropped and the receiver hunts again.
// The rsp register holds a result until its transfer; a new byte is taken while
// it waits, and only a further result stalls until the register is free.
// The csr channel is always ready and must be written while the block is idle.
// Reset clears the receiver, drops any held result and restores the registers.
module packet_sync_fec_receiver_core #(
   parameter int FEC_BYTES = psfr_pkg::FEC_BYTES_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   psfr_req_if.sink      req_bus,
   psfr_rsp_if.source    rsp_bus,
   psfr_csr_if.sink      csr_bus
);

   localparam int PKT_BYTES = 2 * FEC_BYTES;
   localparam int PKT_BITS  = 8 * PKT_BYTES;
   localparam int DATA_BITS = 8 * FEC_BYTES;
   localparam int STEP_W    = $clog2(PKT_BITS);
   localparam int ROW_W     = (FEC_BYTES > 1) ? $clog2(FEC_BYTES) : 1;

   psfr_pkg::state_type state_ff, state_in;

   logic [7:0]                    byte_ff, byte_in;
   logic [3:0]                    bit_cnt_ff, bit_cnt_in;
   logic                          diff_ff, diff_in;
   logic [psfr_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [psfr_pkg::THRESH_W-1:0] hunt_cnt_ff, hunt_cnt_in;
   logic                          synced_ff, synced_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [2:0]                    digit_ff, digit_in;
   logic [psfr_pkg::WINDOW_W-1:0] cmp_ff, cmp_in;
   logic [psfr_pkg::THRESH_W-1:0] eq_ff, eq_in;
   logic [PKT_BITS-1:0]           store_ff, store_in;
   logic [PKT_BITS-1:0]           buf_ff, buf_in;
   logic [6:0]                    sreg_ff, sreg_in;
   logic [7:0]                    syn_ff, syn_in;
   logic [psfr_pkg::WINDOW_W-1:0] pattern_ff, pattern_in;
   logic [psfr_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    opcode_ff, argument_ff;
   logic [15:0]                   unit_ident_ff, crc_field_ff;

   logic                          diff_new;
   logic [psfr_pkg::WINDOW_W-1:0] window_new;
   logic [psfr_pkg::THRESH_W-1:0] hunt_next;
   logic [3:0]                    bit_cnt_new;
   logic [psfr_pkg::THRESH_W-1:0] eq_sum;
   logic                          sync_hit;
   logic [PKT_BITS-1:0]           store_rot16;
   logic [6:0]                    sreg_new;
   logic                          parity;
   logic [7:0]                    syn_shift;
   logic [2:0]                    votes;
   logic                          fix;
   logic [PKT_BITS-1:0]           buf_fixed;
   logic                          clear_rx;
   logic                          rsp_load;

   function automatic logic [7:0] pkt_byte(input logic [PKT_BITS-1:0] value, input int idx);
      logic [PKT_BITS-1:0] shifted;
      shifted = '0;
      if (idx < FEC_BYTES) begin
         shifted = value >> (8 * (FEC_BYTES + idx));
      end else if (idx < PKT_BYTES) begin
         shifted = value >> (8 * (idx - FEC_BYTES));
      end
      return shifted[7:0];
   endfunction

   assign diff_new    = diff_ff ^ byte_ff[7];
   assign window_new  = {window_ff[psfr_pkg::WINDOW_W-2:0], diff_new};
   assign hunt_next   = (hunt_cnt_ff < psfr_pkg::WINDOW_BITS) ? hunt_cnt_ff + 1'b1 : hunt_cnt_ff;
   assign bit_cnt_new = bit_cnt_ff + 4'd1;
   assign eq_sum      = eq_ff + {2'b00, psfr_pkg::popcount8(
                           cmp_ff[psfr_pkg::WINDOW_W-1 -: psfr_pkg::DIGIT_W])};
   assign sync_hit    = (eq_sum >= thresh_ff) ||
                        ((psfr_pkg::WINDOW_BITS - eq_sum) >= thresh_ff);
   assign store_rot16 = (store_ff << 16) | (store_ff >> (PKT_BITS - 16));

   assign sreg_new  = {sreg_ff[5:0], buf_ff[0]};
   assign parity    = sreg_new[6] ^ sreg_new[5] ^ sreg_new[2] ^ sreg_new[0];
   assign syn_shift = {syn_ff[6:0], parity ^ buf_ff[DATA_BITS]};
   assign votes     = {2'b00, syn_shift[7]} + {2'b00, syn_shift[5]} +
                      {2'b00, syn_shift[2]} + {2'b00, syn_shift[1]};
   assign fix       = (votes >= psfr_pkg::FEC_VOTE_MIN);

   always_comb begin
      buf_fixed = buf_ff;
      if (fix && (step_ff >= STEP_W'(7))) begin
         buf_fixed[PKT_BITS-7] = ~buf_ff[PKT_BITS-7];
      end
   end

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      bit_cnt_in  = bit_cnt_ff;
      diff_in     = diff_ff;
      window_in   = window_ff;
      hunt_cnt_in = hunt_cnt_ff;
      synced_in   = synced_ff;
      step_in     = step_ff;
      row_in      = row_ff;
      digit_in    = digit_ff;
      cmp_in      = cmp_ff;
      eq_in       = eq_ff;
      store_in    = store_ff;
      buf_in      = buf_ff;
      sreg_in     = sreg_ff;
      syn_in      = syn_ff;
      clear_rx    = 1'b0;
      rsp_load    = 1'b0;

      case (state_ff)
         psfr_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.kind) begin
                  clear_rx = 1'b1;
               end else begin
                  byte_in    = req_bus.rx_byte;
                  bit_cnt_in = '0;
                  state_in   = psfr_pkg::ST_BIT;
               end
            end
         end
         psfr_pkg::ST_BIT: begin
            byte_in    = {byte_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_new;
            diff_in    = diff_new;
            window_in  = window_new;
            if (!synced_ff) begin
               hunt_cnt_in = hunt_next;
               if (hunt_next == psfr_pkg::WINDOW_BITS) begin
                  cmp_in   = ~(window_new ^ pattern_ff);
                  eq_in    = '0;
                  digit_in = '0;
                  state_in = psfr_pkg::ST_COUNT;
               end else if (bit_cnt_new == psfr_pkg::BITS_PER_BYTE) begin
                  state_in = psfr_pkg::ST_IDLE;
               end
            end else begin
               store_in = {store_ff[PKT_BITS-2:0], diff_new};
               if (step_ff == STEP_W'(PKT_BITS - 1)) begin
                  step_in  = '0;
                  row_in   = '0;
                  state_in = psfr_pkg::ST_DEINT;
               end else begin
                  step_in = step_ff + 1'b1;
                  if (bit_cnt_new == psfr_pkg::BITS_PER_BYTE) begin
                     state_in = psfr_pkg::ST_IDLE;
                  end
               end
            end
         end
         psfr_pkg::ST_COUNT: begin
            eq_in    = eq_sum;
            cmp_in   = cmp_ff << psfr_pkg::DIGIT_W;
            digit_in = digit_ff + 3'd1;
            if (digit_ff == 3'(psfr_pkg::DIGITS - 1)) begin
               if (sync_hit) begin
                  synced_in   = 1'b1;
                  hunt_cnt_in = '0;
                  step_in     = '0;
               end
               state_in = (bit_cnt_ff == psfr_pkg::BITS_PER_BYTE) ?
                          psfr_pkg::ST_IDLE : psfr_pkg::ST_BIT;
            end
         end
         psfr_pkg::ST_DEINT: begin
            buf_in  = {store_ff[PKT_BITS-1], buf_ff[PKT_BITS-1:1]};
            step_in = step_ff + 1'b1;
            if (row_ff == ROW_W'(FEC_BYTES - 1)) begin
               store_in = {store_rot16[PKT_BITS-2:0], store_rot16[PKT_BITS-1]};
               row_in   = '0;
            end else begin
               store_in = store_rot16;
               row_in   = row_ff + 1'b1;
            end
            if (step_ff == STEP_W'(PKT_BITS - 1)) begin
               step_in  = '0;
               sreg_in  = '0;
               syn_in   = '0;
               state_in = psfr_pkg::ST_FEC;
            end
         end
         psfr_pkg::ST_FEC: begin
            buf_in  = {buf_fixed[0], buf_fixed[PKT_BITS-1:1]};
            sreg_in = sreg_new;
            syn_in  = fix ? (syn_shift ^ psfr_pkg::FEC_FIX_MASK) : syn_shift;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DATA_BITS - 1)) begin
               state_in = psfr_pkg::ST_PUSH;
            end
         end
         psfr_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               clear_rx = 1'b1;
               state_in = psfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psfr_pkg::ST_IDLE;
         end
      endcase

      if (clear_rx) begin
         diff_in     = 1'b0;
         window_in   = '0;
         hunt_cnt_in = '0;
         synced_in   = 1'b0;
         step_in     = '0;
      end
   end

   always_comb begin
      pattern_in = pattern_ff;
      thresh_in  = thresh_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            psfr_pkg::CSR_SYNC_PATTERN:   pattern_in = csr_bus.wdata;
            psfr_pkg::CSR_SYNC_THRESHOLD: thresh_in  = csr_bus.wdata[psfr_pkg::THRESH_W-1:0];
            default: begin
               pattern_in = pattern_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psfr_pkg::ST_IDLE;
         diff_ff      <= 1'b0;
         window_ff    <= '0;
         hunt_cnt_ff  <= '0;
         synced_ff    <= 1'b0;
         step_ff      <= '0;
         row_ff       <= '0;
         digit_ff     <= '0;
         bit_cnt_ff   <= '0;
         pattern_ff   <= psfr_pkg::SYNC_PATTERN_RESET;
         thresh_ff    <= psfr_pkg::SYNC_THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         diff_ff      <= diff_in;
         window_ff    <= window_in;
         hunt_cnt_ff  <= hunt_cnt_in;
         synced_ff    <= synced_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         digit_ff     <= digit_in;
         bit_cnt_ff   <= bit_cnt_in;
         pattern_ff   <= pattern_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      cmp_ff   <= cmp_in;
      eq_ff    <= eq_in;
      store_ff <= store_in;
      buf_ff   <= buf_in;
      sreg_ff  <= sreg_in;
      syn_ff   <= syn_in;
      if (rsp_load) begin
         opcode_ff     <= pkt_byte(buf_ff, 0);
         argument_ff   <= pkt_byte(buf_ff, 1);
         unit_ident_ff <= {pkt_byte(buf_ff, 2), pkt_byte(buf_ff, 3)};
         crc_field_ff  <= {pkt_byte(buf_ff, 5), pkt_byte(buf_ff, 4)};
      end
   end

   assign req_bus.ready      = (state_ff == psfr_pkg::ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.opcode     = opcode_ff;
   assign rsp_bus.argument   = argument_ff;
   assign rsp_bus.unit_ident = unit_ident_ff;
   assign rsp_bus.crc_field  = crc_field_ff;

endmodule

FILE: rtl/psfr_checker.sv
// Port-level checks of the packet receiver and their attachment to the top level.
`include "packet_sync_fec_receiver_core_defines.svh"

module psfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_opcode,
   input logic [7:0]  rsp_argument,
   input logic [15:0] rsp_unit_ident,
   input logic [15:0] rsp_crc_field
);

   // A held result keeps its fields until its transfer.
   `PSFR_ASSERT_NEXT(rsp_hold_a, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_opcode) && $stable(rsp_argument) && $stable(rsp_unit_ident) && $stable(rsp_crc_field))

   // A data byte keeps the receiver busy for at least its bit pass.
   `PSFR_ASSERT_NEXT(byte_busy_a, req_valid && req_ready && !req_kind, !req_ready)

   // A new result only follows a busy cycle spent on packet decoding.
   `PSFR_ASSERT_SAME(rsp_after_busy_a, $rose(rsp_valid), !$past(req_ready))

endmodule

bind packet_sync_fec_receiver_core psfr_checker u_psfr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_kind       (req_bus.kind),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_opcode     (rsp_bus.opcode),
   .rsp_argument   (rsp_bus.argument),
   .rsp_unit_ident (rsp_bus.unit_ident),
   .rsp_crc_field  (rsp_bus.crc_field)
);

FILE: tb/sv/tb_packet_sync_fec_receiver_core.sv
// Self-checking testbench for the sync-word framed packet receiver with FEC correction.
module tb_packet_sync_fec_receiver_core;

   localparam int FEC_BYTES       = psfr_pkg::FEC_BYTES_DEFAULT;
   localparam int WINDOW_W        = psfr_pkg::WINDOW_W;
   localparam int THRESH_W        = psfr_pkg::THRESH_W;
   localparam int PKT_BYTES       = 2 * FEC_BYTES;
   localparam int SETTLE_CYCLES   = 300;
   localparam int ITEMS_PER_PHASE = 178;
   localparam int STIM_ROWS       = 23;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  argument;
      logic [15:0] unit_ident;
      logic [15:0] crc_field;
   } frame_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rxb;
      logic       typed;
      logic       has_rsp;
      frame_type  frame;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   psfr_req_if req_bus ();
   psfr_rsp_if rsp_bus ();
   psfr_csr_if csr_bus ();

   packet_sync_fec_receiver_core #(
      .FEC_BYTES(FEC_BYTES)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   logic [WINDOW_W-1:0] cfg_pattern;
   logic [THRESH_W-1:0] cfg_threshold;
   logic                rx_diff;
   logic [39:0]         rx_window;
   int                  rx_count;
   logic                rx_synced;
   int                  rx_index;
   logic [7:0]          rx_store [0:PKT_BYTES-1];

   frame_type     pending_frames [$];
   int            mismatches = 0;
   int            items_sent = 0;
   idle_mode_type idle_mode  = IDLE_NONE;
   stim_row_type  stim_table [0:STIM_ROWS-1];

   function automatic void clear_receiver();
      rx_diff   = 1'b0;
      rx_window = '0;
      rx_count  = 0;
      rx_synced = 1'b0;
      rx_index  = 0;
      for (int i = 0; i < PKT_BYTES; i++) rx_store[i] = '0;
   endfunction

   // Deinterleaves the stored packet over sixteen columns, then runs the syndrome decoder.
   function automatic frame_type decode_frame();
      logic [7:0]             dec [0:31];
      logic [PKT_BYTES*8-1:0] bits;
      logic [7:0]             data;
      logic [7:0]             sreg;
      logic [7:0]             syn;
      logic                   par;
      int                     k;
      int                     n;
      int                     pos;
      int                     votes;
      frame_type              res;
      for (int i = 0; i < 32; i++) dec[i] = '0;
      k = 0;
      for (int col = 0; col < 16; col++) begin
         for (int row = 0; row < FEC_BYTES; row++) begin
            n = row * 16 + col;
            bits[k] = rx_store[n / 8][7 - (n % 8)];
            k++;
         end
      end
      for (int i = 0; i < PKT_BYTES; i++) begin
         for (int b = 0; b < 8; b++) dec[i][b] = bits[i * 8 + b];
      end
      sreg = '0;
      syn  = '0;
      for (int i = 0; i < FEC_BYTES; i++) begin
         data = dec[i];
         for (int b = 0; b < 8; b++) begin
            sreg  = {sreg[6:0], data[b]};
            par   = sreg[6] ^ sreg[5] ^ sreg[2] ^ sreg[0];
            syn   = {syn[6:0], par ^ dec[i + FEC_BYTES][b]};
            votes = int'(syn[7]) + int'(syn[5]) + int'(syn[2]) + int'(syn[1]);
            if (votes >= int'(psfr_pkg::FEC_VOTE_MIN)) begin
               pos = i * 8 + b;
               if (pos >= 7) begin
                  pos = pos - 7;
                  dec[pos / 8][pos % 8] = ~dec[pos / 8][pos % 8];
               end
               syn = syn ^ psfr_pkg::FEC_FIX_MASK;
            end
         end
      end
      res.opcode     = dec[0];
      res.argument   = dec[1];
      res.unit_ident = {dec[2], dec[3]};
      res.crc_field  = {dec[5], dec[4]};
      return res;
   endfunction

   // Advances the receiver state by one transfer; returns 1 when a packet completes.
   function automatic bit predict_byte(input logic kind, input logic [7:0] rxb,
                                       output frame_type res);
      int eq;
      res = '0;
      if (kind) begin
         clear_receiver();
         return 1'b0;
      end
      for (int p = 7; p >= 0; p--) begin
         rx_diff   = rx_diff ^ rxb[p];
         rx_window = {rx_window[38:0], rx_diff};
         if (!rx_synced) begin
            if (rx_count < 40) rx_count++;
            if (rx_count >= 40) begin
               eq = $countones(~(rx_window ^ cfg_pattern));
               if (eq >= int'(cfg_threshold) || (40 - eq) >= int'(cfg_threshold)) begin
                  rx_synced = 1'b1;
                  rx_index  = 0;
                  rx_count  = 0;
               end
            end
            continue;
         end
         rx_count++;
         if (rx_count < 8) continue;
         rx_count = 0;
         if (rx_index < PKT_BYTES) rx_store[rx_index] = rx_window[7:0];
         rx_index++;
         if (rx_index < PKT_BYTES) continue;
         res = decode_frame();
         clear_receiver();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (idle_mode == IDLE_RECEIVER) begin
         rsp_bus.ready <= ($urandom_range(99) >= 45);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_bus.ready <= ($urandom_range(99) >= 14);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: op=%h arg=%h unit=%h crc=%h", rsp_bus.opcode,
                        rsp_bus.argument, rsp_bus.unit_ident, rsp_bus.crc_field);
            end
         end else begin
            want = pending_frames.pop_front();
            if (rsp_bus.opcode !== want.opcode || rsp_bus.argument !== want.argument ||
                rsp_bus.unit_ident !== want.unit_ident ||
                rsp_bus.crc_field !== want.crc_field) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected op=%h arg=%h unit=%h crc=%h", want.opcode,
                           want.argument, want.unit_ident, want.crc_field);
                  $display("          actual   op=%h arg=%h unit=%h crc=%h", rsp_bus.opcode,
                           rsp_bus.argument, rsp_bus.unit_ident, rsp_bus.crc_field);
               end
            end
         end
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] rxb, input bit typed,
                            input bit typed_rsp, input frame_type typed_frame);
      int        pct;
      int        gap;
      bit        got;
      frame_type frame;
      pct = (idle_mode == IDLE_SENDER) ? 45 : (idle_mode == IDLE_BOTH) ? 14 : 0;
      gap = 0;
      while ($urandom_range(99) < pct) gap++;
      if (pct != 0 && $urandom_range(49) == 0) gap = gap + $urandom_range(250, 20);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.rx_byte <= rxb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      got = predict_byte(kind, rxb, frame);
      if (typed) begin
         got   = typed_rsp;
         frame = typed_frame;
      end
      if (got) pending_frames.push_back(frame);
      items_sent++;
   endtask

   // Sends the channel byte whose differential decode yields the given eight bits.
   task automatic send_decoded(input logic [7:0] bits);
      send_item(1'b0, bits ^ {rx_diff, bits[7:1]}, 1'b0, 1'b0, '0);
   endtask

   task automatic send_packet();
      logic [39:0] word;
      int          flips;
      int          len;
      int          pick;
      logic [7:0]  payload;
      if ($urandom_range(1) == 1) send_item(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
      word = cfg_pattern;
      if ($urandom_range(1) == 1) word = ~word;
      flips = ($urandom_range(2) == 0) ? $urandom_range(10) : 0;
      for (int i = 0; i < flips; i++) word[$urandom_range(39)] = ~word[$urandom_range(39)];
      for (int i = 4; i >= 0; i--) send_decoded(word[i*8 +: 8]);
      len = ($urandom_range(9) == 0) ? $urandom_range(13) : PKT_BYTES;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(19);
         payload = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
         send_decoded(payload);
      end
      if (len < PKT_BYTES && $urandom_range(1) == 1) begin
         send_item(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
      end
   endtask

   task automatic wait_drained(input int tail);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic [psfr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [WINDOW_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == psfr_pkg::CSR_SYNC_PATTERN) cfg_pattern = value;
      else if (idx == psfr_pkg::CSR_SYNC_THRESHOLD) cfg_threshold = value[THRESH_W-1:0];
   endtask

   task automatic configure(input logic [WINDOW_W-1:0] pattern, input int threshold);
      write_csr(psfr_pkg::CSR_SYNC_PATTERN, pattern);
      write_csr(psfr_pkg::CSR_SYNC_THRESHOLD, WINDOW_W'(threshold));
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [WINDOW_W-1:0] random_pattern();
      return {8'($urandom_range(255)), 32'($urandom)};
   endfunction

   initial begin
      int start;
      int pick;
      int burst;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.wdata   <= '0;
      cfg_pattern     = psfr_pkg::SYNC_PATTERN_RESET;
      cfg_threshold   = psfr_pkg::SYNC_THRESHOLD_RESET;
      clear_receiver();

      // The sync rows carry the reset sync word; the zero payload decodes to all zero fields.
      stim_table = '{
         '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
         '{1'b1, 8'h00, 1'b1, 1'b0, '0},
         '{1'b0, 8'h04, 1'b0, 1'b0, '0},
         '{1'b0, 8'h8D, 1'b0, 1'b0, '0},
         '{1'b0, 8'hBF, 1'b0, 1'b0, '0},
         '{1'b0, 8'h66, 1'b0, 1'b0, '0},
         '{1'b0, 8'h58, 1'b0, 1'b0, '0},
         '{1'b0, 8'h80, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, 8'h00, 1'b1, 1'b1, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < STIM_ROWS; i++) begin
         send_item(stim_table[i].kind, stim_table[i].rxb, stim_table[i].typed,
                   stim_table[i].has_rsp, stim_table[i].frame);
      end

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained(SETTLE_CYCLES);
         case (ph)
            0: configure(psfr_pkg::SYNC_PATTERN_RESET, 32);
            1: configure(random_pattern(), 40);
            2: configure('0, 0);
            3: configure('1, 63);
            4: configure(random_pattern(), $urandom_range(39, 20));
            5: configure(random_pattern(), 41);
            6: configure(psfr_pkg::SYNC_PATTERN_RESET, 1);
            default: configure(random_pattern(), 36);
         endcase
         idle_mode = idle_mode_type'(ph % 4);
         start = items_sent;
         while (items_sent - start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               send_packet();
            end else if (pick < 85) begin
               burst = $urandom_range(6, 1);
               for (int i = 0; i < burst; i++) begin
                  send_item(1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
               end
            end else if (pick < 92) begin
               send_item(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
            end else if (pick < 98) begin
               send_item(1'b0, ($urandom_range(1) == 1) ? 8'hFF : 8'h00, 1'b0, 1'b0, '0);
            end else begin
               wait_drained(0);
            end
         end
      end

      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
